// ===== hdl/lflg_pkg.sv =====
// Shared constants, operation codes and control types of the lagged Fibonacci generator.
`default_nettype none

package lflg_pkg;

    localparam int LONG_LAG_DEFAULT  = 17;
    localparam int SHORT_LAG_DEFAULT = 5;

    localparam int OP_W   = 2;
    localparam int SLOT_W = 5;
    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] LCG_MUL = 64'hd134_2543_de82_ef95;
    localparam logic [WORD_W-1:0] LCG_INC = 64'd1;

    typedef enum logic [OP_W-1:0] {
        OP_GENERATE  = 2'd0,
        OP_LOAD_RING = 2'd1,
        OP_LOAD_LCG  = 2'd2
    } op_t;

    // Commands from the result stage to the LCG.
    typedef struct packed {
        logic step;
        logic load;
    } lcg_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/lflg_ring.sv =====
// Lag ring memory with per-entry valid bits and write-to-read bypass.
`default_nettype none

module lflg_ring
    import lflg_pkg::*;
#(
    parameter int DEPTH = LONG_LAG_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_long_addr,
    input  wire logic [AW-1:0]     rd_short_addr,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    output logic      [WORD_W-1:0] rd_long_data,
    output logic      [WORD_W-1:0] rd_short_data
);

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DEPTH-1:0]  vld_next;
    logic [WORD_W-1:0] rd_long_reg;
    logic [WORD_W-1:0] rd_short_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // A word written at the same edge is forwarded; entries never written read as zero.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_long_addr))
            begin
                rd_long_reg <= wr_data;
            end
            else
            begin
                rd_long_reg <= vld_reg[rd_long_addr] ? mem_reg[rd_long_addr] : '0;
            end
            if (wr_en && (wr_addr == rd_short_addr))
            begin
                rd_short_reg <= wr_data;
            end
            else
            begin
                rd_short_reg <= vld_reg[rd_short_addr] ? mem_reg[rd_short_addr] : '0;
            end
        end
    end

    assign rd_long_data  = rd_long_reg;
    assign rd_short_data = rd_short_reg;

    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(wr_addr) < DEPTH))
        else $error("ring write address beyond depth");

    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (int'(rd_long_addr) < DEPTH) && (int'(rd_short_addr) < DEPTH))
        else $error("ring read address beyond depth");

    a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_addr)])
        else $error("written ring entry not marked valid");

endmodule

`default_nettype wire

// ===== hdl/lflg_lcg.sv =====
// 64-bit linear congruential generator state and its one-step update.
`default_nettype none

module lflg_lcg
    import lflg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcg_ctrl_t         ctrl,
    input  wire logic [WORD_W-1:0] load_value,
    output logic      [WORD_W-1:0] state_step
);

    logic [WORD_W-1:0]   state_reg;
    logic [WORD_W-1:0]   state_next;
    logic [WORD_W-1:0]   prod_low;
    logic [HALF_W-1:0]   prod_cross_a;
    logic [HALF_W-1:0]   prod_cross_b;
    logic [WORD_W-1:0]   prod_mod;

    // Product modulo 2^64 from three 32-bit partial products; the high-by-high
    // term falls entirely above bit 63.
    always_comb
    begin
        prod_low     = WORD_W'(state_reg[HALF_W-1:0]) * WORD_W'(LCG_MUL[HALF_W-1:0]);
        prod_cross_a = state_reg[WORD_W-1:HALF_W] * LCG_MUL[HALF_W-1:0];
        prod_cross_b = state_reg[HALF_W-1:0] * LCG_MUL[WORD_W-1:HALF_W];
        prod_mod     = prod_low + {prod_cross_a + prod_cross_b, {HALF_W{1'b0}}};
        state_step   = prod_mod + LCG_INC;
    end

    always_comb
    begin
        priority if (ctrl.load)
        begin
            state_next = load_value;
        end
        else if (ctrl.step)
        begin
            state_next = state_step;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_ctrl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.step))
        else $error("LCG load and step in the same cycle");

    a_step_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && !ctrl.load) |=> (state_reg == $past(state_step)))
        else $error("LCG step not applied");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.step && !ctrl.load) |=> $stable(state_reg))
        else $error("LCG state changed without a command");

endmodule

`default_nettype wire

// ===== hdl/lagged_fibonacci_lcg_mix_generator.sv =====
// Top level: lagged Fibonacci generator (lags 17 and 5) whitened by a 64-bit LCG.
// A generate transaction accepted at one edge has its ring words registered and enters
// the result stage; its word is registered onto random_word when that stage commits.
// Throughput: one transaction per cycle unless the output stalls; the single result
// stage adds both ring words, steps the LCG and writes the ring back at the same edge.
// Reset: the ring reads as zero through per-entry valid bits (no clearing pass), the
// LCG state is zero and the pointers return to LONG_LAG and SHORT_LAG.
`default_nettype none

module lagged_fibonacci_lcg_mix_generator
    import lflg_pkg::*;
#(
    parameter int LONG_LAG  = LONG_LAG_DEFAULT,
    parameter int SHORT_LAG = SHORT_LAG_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [WORD_W-1:0] load_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [WORD_W-1:0] random_word
);

    localparam int AW = $clog2(LONG_LAG);
    localparam logic [AW-1:0] LONG_IDX_START  = AW'(LONG_LAG - 1);
    localparam logic [AW-1:0] SHORT_IDX_START = AW'(SHORT_LAG - 1);
    localparam logic [AW-1:0] LAST_IDX        = AW'(LONG_LAG - 1);

    // The pointers are kept as ring indexes, position minus one. They move when a
    // transaction is accepted, so the ring read for that transaction can be issued
    // at the acceptance edge.
    logic [AW-1:0] long_idx_reg;
    logic [AW-1:0] long_idx_next;
    logic [AW-1:0] short_idx_reg;
    logic [AW-1:0] short_idx_next;

    // Result stage: holds one accepted transaction until it commits.
    logic              b_vld_reg;
    logic              b_vld_next;
    op_t               b_op_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    logic [WORD_W-1:0] b_value_reg;
    logic [AW-1:0]     b_long_idx_reg;

    logic              out_vld_reg;
    logic              out_vld_next;
    logic [WORD_W-1:0] word_reg;

    logic              in_accept;
    logic              b_gen;
    logic              b_adv;
    logic              b_slot_ok;
    logic [SLOT_W-1:0] b_slot_m1;
    logic [WORD_W-1:0] rd_long_data;
    logic [WORD_W-1:0] rd_short_data;
    logic [WORD_W-1:0] lag_sum;
    logic [WORD_W-1:0] lcg_step;
    logic              ring_wr_en;
    logic [AW-1:0]     ring_wr_addr;
    logic [WORD_W-1:0] ring_wr_data;
    lcg_ctrl_t         lcg_ctrl;

    // The result stage moves on when its transaction makes no word, or when the
    // output register is empty or being drained at the same edge.
    assign b_gen     = b_vld_reg && (b_op_reg == OP_GENERATE);
    assign b_adv     = b_vld_reg && (!b_gen || !out_vld_reg || !out_stall);
    assign in_stall  = b_vld_reg && !b_adv;
    assign in_accept = in_valid && !in_stall;

    // Pointer update at acceptance; the unused op code leaves them alone.
    always_comb
    begin
        long_idx_next  = long_idx_reg;
        short_idx_next = short_idx_reg;
        if (in_accept)
        begin
            unique case (op_t'(op))
                OP_GENERATE:
                begin
                    long_idx_next  = (long_idx_reg == '0) ? LAST_IDX : long_idx_reg - 1'b1;
                    short_idx_next = (short_idx_reg == '0) ? LAST_IDX : short_idx_reg - 1'b1;
                end
                OP_LOAD_RING, OP_LOAD_LCG:
                begin
                    long_idx_next  = LONG_IDX_START;
                    short_idx_next = SHORT_IDX_START;
                end
                default:
                begin
                    long_idx_next  = long_idx_reg;
                    short_idx_next = short_idx_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (in_accept)
        begin
            b_vld_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_vld_next = 1'b0;
        end
        else
        begin
            b_vld_next = b_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_idx_reg  <= LONG_IDX_START;
            short_idx_reg <= SHORT_IDX_START;
            b_vld_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            long_idx_reg  <= long_idx_next;
            short_idx_reg <= short_idx_next;
            b_vld_reg     <= b_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // The unused op code is carried as-is; the result stage ignores it.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_op_reg       <= op_t'(op);
            b_slot_reg     <= slot;
            b_value_reg    <= load_value;
            b_long_idx_reg <= long_idx_reg;
        end
    end

    lflg_ring #(
        .DEPTH (LONG_LAG),
        .AW    (AW)
    ) u_ring (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_en         (in_accept),
        .rd_long_addr  (long_idx_reg),
        .rd_short_addr (short_idx_reg),
        .wr_en         (ring_wr_en),
        .wr_addr       (ring_wr_addr),
        .wr_data       (ring_wr_data),
        .rd_long_data  (rd_long_data),
        .rd_short_data (rd_short_data)
    );

    // A ring load outside 1..LONG_LAG writes nothing but still resets the pointers.
    assign b_slot_m1 = b_slot_reg - 1'b1;
    assign b_slot_ok = (b_slot_reg != '0) && (int'(b_slot_reg) <= LONG_LAG);
    assign lag_sum   = rd_long_data + rd_short_data;

    always_comb
    begin
        ring_wr_en   = 1'b0;
        ring_wr_addr = b_long_idx_reg;
        ring_wr_data = lag_sum;
        if (b_adv)
        begin
            if (b_gen)
            begin
                ring_wr_en = 1'b1;
            end
            else if ((b_op_reg == OP_LOAD_RING) && b_slot_ok)
            begin
                ring_wr_en   = 1'b1;
                ring_wr_addr = AW'(b_slot_m1);
                ring_wr_data = b_value_reg;
            end
        end
    end

    assign lcg_ctrl.step = b_adv && b_gen;
    assign lcg_ctrl.load = b_adv && (b_op_reg == OP_LOAD_LCG);

    lflg_lcg u_lcg (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lcg_ctrl),
        .load_value (b_value_reg),
        .state_step (lcg_step)
    );

    // Output register: the word is the lagged sum mixed with the new LCG state.
    always_comb
    begin
        priority if (b_adv && b_gen)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && b_gen)
        begin
            word_reg <= lag_sum ^ lcg_step;
        end
    end

    assign out_valid   = out_vld_reg;
    assign random_word = word_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (b_vld_reg && b_gen && out_vld_reg))
        else $error("input stalled without a blocked generate transaction");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(long_idx_reg) < LONG_LAG) && (int'(short_idx_reg) < LONG_LAG))
        else $error("pointer index beyond ring depth");

    a_lag_distance: assert property (@(posedge clk) disable iff (!rst_n)
        ((long_idx_reg >= short_idx_reg) &&
         (int'(long_idx_reg) - int'(short_idx_reg) == LONG_LAG - SHORT_LAG)) ||
        ((long_idx_reg < short_idx_reg) &&
         (int'(long_idx_reg) + LONG_LAG - int'(short_idx_reg) == LONG_LAG - SHORT_LAG)))
        else $error("long and short pointers lost their lag distance");

    a_gen_makes_word: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && b_gen) |=> out_vld_reg)
        else $error("committed generate transaction produced no word");

endmodule

`default_nettype wire

// ===== tb/lagged_fibonacci_lcg_mix_generator_tb.sv =====
// Self-checking testbench for the lagged Fibonacci generator with LCG whitening.
module lagged_fibonacci_lcg_mix_generator_tb;

    import lflg_pkg::*;

    // The block is built with its default lags, so the mirror uses the same ones.
    localparam int LONG_LAG  = LONG_LAG_DEFAULT;
    localparam int SHORT_LAG = SHORT_LAG_DEFAULT;

    // Code 3 has no operation behind it; the block must drop such a transaction.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Number of non-ignored transactions in the random part.
    localparam int RANDOM_ITEMS = 1900;

    // Watchdog limit, well above what the slowest legal run (heavy output stall plus the
    // longest sender gaps) needs for this many transactions.
    localparam int CYCLE_LIMIT = 200000;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   op         = '0;
    logic [SLOT_W-1:0] slot       = '0;
    logic [WORD_W-1:0] load_value = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [WORD_W-1:0] random_word;

    // Mirror of the generator state, updated whenever the block accepts a
    // transaction. Ring positions run from 1 to LONG_LAG as in the block.
    logic [WORD_W-1:0] ring_words [1:LONG_LAG];
    logic [WORD_W-1:0] lcg_word;
    int unsigned       long_pos;
    int unsigned       short_pos;

    // Words the block still owes us, oldest first.
    logic [WORD_W-1:0] expected_words [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int items_sent     = 0;

    // Sender burst bookkeeping: transactions left before the next gap.
    int burst_left = 0;

    // Receiver stall pattern: a mode that holds for a random stretch.
    int stall_mode       = 0;
    int stall_phase_left = 0;

    lagged_fibonacci_lcg_mix_generator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .slot        (slot),
        .load_value  (load_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    always #1 clk = ~clk;

    // Pointer step: down by one, wrapping from position 1 back to LONG_LAG.
    function automatic int unsigned step_down(input int unsigned pos);
        if (pos <= 1 || pos > LONG_LAG)
            return LONG_LAG;
        return pos - 1;
    endfunction

    // Applies one accepted transaction to the mirror and queues the word a
    // generate must produce. Loads of either kind rewind both pointers, even
    // when the ring slot is out of range and nothing gets written.
    function automatic void predict_transaction(input logic [OP_W-1:0] code,
                                                input logic [SLOT_W-1:0] pos,
                                                input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] lagged_sum;
        case (code)
            OP_GENERATE:
            begin
                lagged_sum = ring_words[long_pos] + ring_words[short_pos];
                ring_words[long_pos] = lagged_sum;
                lcg_word = lcg_word * LCG_MUL + LCG_INC;
                long_pos = step_down(long_pos);
                short_pos = step_down(short_pos);
                expected_words.push_back(lagged_sum ^ lcg_word);
            end
            OP_LOAD_RING:
            begin
                if (pos >= 1 && pos <= LONG_LAG)
                    ring_words[pos] = value;
                long_pos = LONG_LAG;
                short_pos = SHORT_LAG;
            end
            OP_LOAD_LCG:
            begin
                lcg_word = value;
                long_pos = LONG_LAG;
                short_pos = SHORT_LAG;
            end
            default:
            begin
                // Unused code: the block ignores the transaction entirely.
            end
        endcase
    endfunction

    initial
    begin
        for (int i = 1; i <= LONG_LAG; i++)
            ring_words[i] = '0;
        lcg_word = '0;
        long_pos = LONG_LAG;
        short_pos = SHORT_LAG;
    end

    // Both handshakes are sampled at the rising edge, before any of this
    // edge's nonblocking updates land. A generate accepted at this edge cannot
    // show its word before the next one, so checking the output first is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: random_word expected none, got %h", $time, random_word);
                    mismatch_count++;
                end
                else
                begin
                    logic [WORD_W-1:0] want;
                    want = expected_words.pop_front();
                    if (random_word !== want)
                    begin
                        $display("%0t: random_word expected %h, got %h",
                                 $time, want, random_word);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_transaction(op, slot, load_value);
        end
    end

    // The receiver switches between free flow, random stalls, a periodic
    // pattern and heavy back-pressure, each held for a random stretch.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_phase_left <= $urandom_range(20, 200);
        end
        else
            stall_phase_left <= stall_phase_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= (cycle_count[2:0] < 3);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lagged_fibonacci_lcg_mix_generator_tb failed");
            $finish;
        end
    end

    // Random 64-bit word, biased toward zero, all ones and single set bits.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Random slot over the whole 5-bit field, including out-of-range values.
    function automatic logic [SLOT_W-1:0] pick_any_slot();
        return SLOT_W'($urandom_range(0, 31));
    endfunction

    // Random slot inside the ring.
    function automatic logic [SLOT_W-1:0] pick_ring_slot();
        return SLOT_W'($urandom_range(1, LONG_LAG));
    endfunction

    // Ends a burst with a random gap, or keeps valid high for the next one.
    // Valid is only lowered when a gap really follows, so it never drops and
    // rises within one time step.
    task automatic pause_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Presents one transaction and holds it until the block takes it.
    task automatic send_transaction(input logic [OP_W-1:0] code,
                                    input logic [SLOT_W-1:0] pos,
                                    input logic [WORD_W-1:0] value);
        in_valid <= 1'b1;
        op <= code;
        slot <= pos;
        load_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (code != OP_UNUSED)
            items_sent++;
        pause_sender();
    endtask

    // From reset the ring is all zero, so the words are the LCG sequence alone.
    task automatic test_zero_state();
        repeat (3)
            send_transaction(OP_GENERATE, pick_any_slot(), pick_word());
    endtask

    // Extreme ring and LCG values, with the first sum overflowing 64 bits.
    task automatic test_load_extremes();
        send_transaction(OP_LOAD_RING, 5'd1, '1);
        send_transaction(OP_LOAD_RING, 5'd17, '1);
        send_transaction(OP_LOAD_RING, 5'd5, {1'b1, {(WORD_W-1){1'b0}}});
        send_transaction(OP_LOAD_RING, 5'd16, '0);
        send_transaction(OP_LOAD_LCG, 5'd0, '1);
        send_transaction(OP_GENERATE, 5'd31, '1);
        send_transaction(OP_GENERATE, 5'd0, '0);
    endtask

    // Ring loads with slot 0 or past the last position write nothing but still
    // rewind the pointers.
    task automatic test_bad_slot();
        send_transaction(OP_LOAD_RING, 5'd0, '1);
        send_transaction(OP_LOAD_RING, 5'd18, '1);
        send_transaction(OP_LOAD_RING, 5'd31, '1);
        send_transaction(OP_GENERATE, 5'd0, '0);
    endtask

    // The unused code must leave the state alone and produce nothing.
    task automatic test_unused_op();
        send_transaction(OP_GENERATE, 5'd3, pick_word());
        send_transaction(OP_UNUSED, 5'd17, '1);
        send_transaction(OP_GENERATE, 5'd3, pick_word());
    endtask

    // A zero LCG seed after a run, then one more word.
    task automatic test_lcg_zero();
        send_transaction(OP_LOAD_LCG, 5'd9, '0);
        send_transaction(OP_GENERATE, 5'd9, '1);
    endtask

    // Mostly reseeds followed by long generate runs, so the pointers wrap many
    // times, mixed with single loads and fully random noise.
    task automatic test_random_sequences();
        int pick;
        int run;
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                run = $urandom_range(1, 45);
                repeat (run)
                    send_transaction(OP_GENERATE, pick_any_slot(), pick_word());
            end
            else if (pick < 7)
            begin
                send_transaction(OP_LOAD_LCG, pick_any_slot(), pick_word());
                if ($urandom_range(0, 2) == 0)
                begin
                    for (int i = 1; i <= LONG_LAG; i++)
                        send_transaction(OP_LOAD_RING, SLOT_W'(i), pick_word());
                end
                else
                begin
                    run = $urandom_range(1, 6);
                    repeat (run)
                        send_transaction(OP_LOAD_RING, pick_ring_slot(), pick_word());
                end
            end
            else if (pick < 9)
            begin
                run = $urandom_range(1, 6);
                repeat (run)
                    send_transaction(OP_W'($urandom_range(0, 3)), pick_any_slot(),
                                     pick_word());
            end
            else if ($urandom_range(0, 1) == 0)
                send_transaction(OP_LOAD_RING, pick_ring_slot(), pick_word());
            else
                send_transaction(OP_LOAD_LCG, pick_any_slot(), pick_word());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_state();
        test_load_extremes();
        test_bad_slot();
        test_unused_op();
        test_lcg_zero();
        items_sent = 0;
        test_random_sequences();

        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // The extra wait catches any word the block invents.
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("lagged_fibonacci_lcg_mix_generator_tb passed");
        else
            $display("lagged_fibonacci_lcg_mix_generator_tb failed");
        $finish;
    end

endmodule
